[rtl/nshq_pkg.sv]
// ----------------------------------------------------------------------------
// nshq_pkg
// shared types and constants of the navigation sensor health qualifier
// ----------------------------------------------------------------------------
package nshq_pkg;

  localparam int LIM_W     = 24;
  localparam int QUAL_W    = 8;
  localparam int HACC_W    = 16;
  localparam int DT_W      = 16;
  localparam int RANGE_W   = 16;
  localparam int FIX_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 24;

  localparam logic [RANGE_W-1:0] SONAR_LIMIT_MM = 16'd4500;
  localparam logic [FIX_W-1:0]   GPS_FIX_3D     = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOW_ON       = 3'd0,
    REG_FLOW_OFF      = 3'd1,
    REG_SONAR_ON      = 3'd2,
    REG_SONAR_OFF     = 3'd3,
    REG_GPS_SWITCH    = 3'd4,
    REG_FLOW_QUAL_MIN = 3'd5,
    REG_HACC_ENTER    = 3'd6,
    REG_HACC_STAY     = 3'd7
  } cfg_idx_t;

  localparam logic [LIM_W-1:0]  RST_FLOW_ON    = 24'd3000000;
  localparam logic [LIM_W-1:0]  RST_FLOW_OFF   = 24'd1000000;
  localparam logic [LIM_W-1:0]  RST_SONAR_ON   = 24'd1000000;
  localparam logic [LIM_W-1:0]  RST_SONAR_OFF  = 24'd500000;
  localparam logic [LIM_W-1:0]  RST_GPS_SWITCH = 24'd3000000;
  localparam logic [QUAL_W-1:0] RST_QUAL_MIN   = 8'd171;
  localparam logic [HACC_W-1:0] RST_HACC_ENTER = 16'd350;
  localparam logic [HACC_W-1:0] RST_HACC_STAY  = 16'd700;

  typedef struct packed {
    logic [LIM_W-1:0]  flow_on_us;
    logic [LIM_W-1:0]  flow_off_us;
    logic [LIM_W-1:0]  sonar_on_us;
    logic [LIM_W-1:0]  sonar_off_us;
    logic [LIM_W-1:0]  gps_switch_us;
    logic [QUAL_W-1:0] flow_quality_min;
    logic [HACC_W-1:0] gps_hacc_enter_cm;
    logic [HACC_W-1:0] gps_hacc_stay_cm;
  } cfg_t;

  typedef struct packed {
    logic [DT_W-1:0]    dt_us;
    logic               sonar_valid;
    logic [RANGE_W-1:0] sonar_mm;
    logic [QUAL_W-1:0]  flow_quality;
    logic [FIX_W-1:0]   gps_fix;
    logic [HACC_W-1:0]  gps_hacc_cm;
  } in_item_t;

  typedef struct packed {
    logic flag_cur;
    logic flag_new;
    logic timer_zero;
  } hyst_stat_t;

endpackage

[rtl/nav_sensor_health_qualifier_unit.sv]
// ----------------------------------------------------------------------------
// nav_sensor_health_qualifier_unit
// qualifies gps, optical flow and sonar health per navigation tick
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    in_tdata, in_tuser
//   out_     out  out_tvalid/out_tready  out_tdata
//   cfg_     in   cfg_we                 cfg_addr, cfg_wdata
//
// one beat per cycle sustained while out_tready is high; an accepted beat goes
// from the input register through the flag logic into the output register
// health state updates as the input register hands over to the output
// synchronous active-low reset loads register defaults and clears all flags
// a stalled output register holds its beat while the input register still
// takes one more beat
// ----------------------------------------------------------------------------
module nav_sensor_health_qualifier_unit
  import nshq_pkg::*;
#(
  parameter int TIMER_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // dt_us[15:0], sonar_mm[31:16], flow_quality[39:32], gps_fix[42:40],
  // gps_hacc_cm[58:43], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // sonar_valid
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // gps_ok[0], flow_ok[1], sonar_ok[2], gps_usable[3], sonar_hold_mm[19:4],
  // cov_open_pulse[20], cov_fail_pulse[21], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  cfg_t       cfg;
  in_item_t   item_r;
  logic       s1_valid_r;
  logic       out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic [RANGE_W-1:0] hold_r;
  logic [RANGE_W-1:0] hold_nxt;
  logic       adv;
  logic       flow_usable;
  logic       sonar_now;
  logic       use_gps;
  logic       open_p;
  logic       fail_p;
  hyst_stat_t flow_st;
  hyst_stat_t sonar_st;
  hyst_stat_t gps_st;

  nshq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.dt_us        <= in_tdata[15:0];
      item_r.sonar_mm     <= in_tdata[31:16];
      item_r.flow_quality <= in_tdata[39:32];
      item_r.gps_fix      <= in_tdata[42:40];
      item_r.gps_hacc_cm  <= in_tdata[58:43];
      item_r.sonar_valid  <= in_tuser;
    end
  end

  always_comb begin
    flow_usable = item_r.sonar_valid && (item_r.flow_quality > cfg.flow_quality_min);
    sonar_now = item_r.sonar_valid && (item_r.sonar_mm != '0) &&
                (item_r.sonar_mm < SONAR_LIMIT_MM);
    use_gps   = ((item_r.gps_fix == GPS_FIX_3D) &&
                 (item_r.gps_hacc_cm < cfg.gps_hacc_enter_cm)) ||
                (gps_st.flag_cur && (item_r.gps_hacc_cm < cfg.gps_hacc_stay_cm));
    open_p    = !gps_st.flag_cur && use_gps && gps_st.timer_zero;
    fail_p    = gps_st.flag_cur && !gps_st.flag_new;
    hold_nxt  = sonar_now ? item_r.sonar_mm : hold_r;
    out_data_nxt = {2'b00, fail_p, open_p, hold_nxt, use_gps,
                    sonar_st.flag_new, flow_st.flag_new, gps_st.flag_new};
  end

  nshq_hyst #(.TIMER_BITS(TIMER_BITS)) u_flow (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .cond    (flow_usable),
    .dt_us   (item_r.dt_us),
    .on_lim  (cfg.flow_on_us),
    .off_lim (cfg.flow_off_us),
    .stat    (flow_st)
  );

  nshq_hyst #(.TIMER_BITS(TIMER_BITS)) u_sonar (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .cond    (sonar_now),
    .dt_us   (item_r.dt_us),
    .on_lim  (cfg.sonar_on_us),
    .off_lim (cfg.sonar_off_us),
    .stat    (sonar_st)
  );

  nshq_hyst #(.TIMER_BITS(TIMER_BITS)) u_gps (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .cond    (use_gps),
    .dt_us   (item_r.dt_us),
    .on_lim  (cfg.gps_switch_us),
    .off_lim (cfg.gps_switch_us),
    .stat    (gps_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        hold_r <= hold_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[20] && out_data_r[21]))
    else $error("open and fail pulses in one beat");

  a_open_usable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[20]) |-> out_data_r[3])
    else $error("open pulse without usable gps");

  a_fail_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[21]) |-> (!out_data_r[0] && !out_data_r[3]))
    else $error("fail pulse while gps healthy or usable");

  a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipe");

endmodule

[rtl/nshq_cfg_regs.sv]
// ----------------------------------------------------------------------------
// nshq_cfg_regs
// configuration register file, write only, one register per index
// ----------------------------------------------------------------------------
module nshq_cfg_regs
  import nshq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_FLOW_ON:       cfg_nxt.flow_on_us        = cfg_wdata;
        REG_FLOW_OFF:      cfg_nxt.flow_off_us       = cfg_wdata;
        REG_SONAR_ON:      cfg_nxt.sonar_on_us       = cfg_wdata;
        REG_SONAR_OFF:     cfg_nxt.sonar_off_us      = cfg_wdata;
        REG_GPS_SWITCH:    cfg_nxt.gps_switch_us     = cfg_wdata;
        REG_FLOW_QUAL_MIN: cfg_nxt.flow_quality_min  = cfg_wdata[QUAL_W-1:0];
        REG_HACC_ENTER:    cfg_nxt.gps_hacc_enter_cm = cfg_wdata[HACC_W-1:0];
        REG_HACC_STAY:     cfg_nxt.gps_hacc_stay_cm  = cfg_wdata[HACC_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flow_on_us        <= RST_FLOW_ON;
      cfg_r.flow_off_us       <= RST_FLOW_OFF;
      cfg_r.sonar_on_us       <= RST_SONAR_ON;
      cfg_r.sonar_off_us      <= RST_SONAR_OFF;
      cfg_r.gps_switch_us     <= RST_GPS_SWITCH;
      cfg_r.flow_quality_min  <= RST_QUAL_MIN;
      cfg_r.gps_hacc_enter_cm <= RST_HACC_ENTER;
      cfg_r.gps_hacc_stay_cm  <= RST_HACC_STAY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/nshq_hyst.sv]
// ----------------------------------------------------------------------------
// nshq_hyst
// health flag with time hysteresis and a saturating disagreement timer
// ----------------------------------------------------------------------------
module nshq_hyst
  import nshq_pkg::*;
#(
  parameter int TIMER_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             cond,
  input  logic [DT_W-1:0]  dt_us,
  input  logic [LIM_W-1:0] on_lim,
  input  logic [LIM_W-1:0] off_lim,
  output hyst_stat_t       stat
);

  logic                  flag_r;
  logic                  flag_nxt;
  logic [TIMER_BITS-1:0] timer_r;
  logic [TIMER_BITS-1:0] timer_nxt;
  logic [TIMER_BITS:0]   sum;
  logic [TIMER_BITS-1:0] sat;
  logic [TIMER_BITS-1:0] lim;
  logic                  disagree;
  logic                  trip;

  always_comb begin
    disagree  = flag_r ^ cond;
    sum       = (TIMER_BITS+1)'(timer_r) + (TIMER_BITS+1)'(dt_us);
    sat       = sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
    lim       = flag_r ? TIMER_BITS'(off_lim) : TIMER_BITS'(on_lim);
    trip      = sat > lim;
    flag_nxt  = (disagree && trip) ? !flag_r : flag_r;
    timer_nxt = (disagree && !trip) ? sat : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r  <= 1'b0;
      timer_r <= '0;
    end else if (step) begin
      flag_r  <= flag_nxt;
      timer_r <= timer_nxt;
    end
  end

  assign stat.flag_cur   = flag_r;
  assign stat.flag_new   = flag_nxt;
  assign stat.timer_zero = (timer_r == '0);

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for nav_sensor_health_qualifier_unit
//
// navigation ticks go in on the in_ stream and one result beat per tick is
// checked against a predictor of the gps, flow and sonar hysteresis flags,
// the gps usable decision, the held sonar range and the covariance pulses.
// directed ticks cover reset values, threshold edges, flag switches, pulses
// and over-wide register writes. random phases run under several register
// settings, extremes included, with random gaps on both sides and one long
// output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top
  import nshq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TMR_W  = 32;
  localparam int N_REGS = 8;
  localparam logic [TMR_W-1:0] TMR_MAX = {TMR_W{1'b1}};

  typedef struct packed {
    logic               fail_p;
    logic               open_p;
    logic [RANGE_W-1:0] hold_mm;
    logic               gps_usable;
    logic               sonar_ok;
    logic               flow_ok;
    logic               gps_ok;
  } health_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DAT_W-1:0]  cfg_wdata = '0;

  nav_sensor_health_qualifier_unit #(.TIMER_BITS(TMR_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  cfg_t               lim;
  logic               gps_flag, flow_flag, sonar_flag;
  logic [TMR_W-1:0]   gps_tmr, flow_tmr, sonar_tmr;
  logic [RANGE_W-1:0] sonar_hold;

  health_res_t        health_q[$];
  health_res_t        exp_r, got_r;
  logic [CFG_DAT_W-1:0] cfg_raw [N_REGS];
  int                 n_err = 0;
  bit                 tx_idle = 1'b1;
  bit                 rx_idle = 1'b1;
  int                 rx_hold_req = 0;
  bit                 gps_good, flow_good, sonar_good;

  task automatic flag_error(input string msg);
    if (n_err < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    n_err++;
  endtask

  // one flag with its timer: counts while the condition disagrees
  task automatic advance_hyst(inout logic flag, inout logic [TMR_W-1:0] tmr,
                              input logic cond, input logic [DT_W-1:0] dt,
                              input logic [LIM_W-1:0] on_lim, off_lim,
                              output logic fell);
    logic [TMR_W:0] sum;
    fell = 1'b0;
    if (flag != cond) begin
      sum = {1'b0, tmr} + (TMR_W+1)'(dt);
      tmr = (sum >= {1'b0, TMR_MAX}) ? TMR_MAX : sum[TMR_W-1:0];
      if (tmr > TMR_W'(flag ? off_lim : on_lim)) begin
        fell = flag;
        flag = ~flag;
        tmr  = '0;
      end
    end else begin
      tmr = '0;
    end
  endtask

  task automatic predict_health(input in_item_t it, output health_res_t r);
    logic flow_usable, in_range, use_gps, fell, unused;
    flow_usable = it.sonar_valid && (it.flow_quality > lim.flow_quality_min);
    in_range = it.sonar_valid && (it.sonar_mm != '0) && (it.sonar_mm < SONAR_LIMIT_MM);
    use_gps  = ((it.gps_fix == GPS_FIX_3D) && (it.gps_hacc_cm < lim.gps_hacc_enter_cm)) ||
               (gps_flag && (it.gps_hacc_cm < lim.gps_hacc_stay_cm));
    r = '0;
    r.open_p = !gps_flag && use_gps && (gps_tmr == '0);
    if (in_range) begin
      sonar_hold = it.sonar_mm;
    end
    advance_hyst(flow_flag, flow_tmr, flow_usable, it.dt_us,
                 lim.flow_on_us, lim.flow_off_us, unused);
    advance_hyst(sonar_flag, sonar_tmr, in_range, it.dt_us,
                 lim.sonar_on_us, lim.sonar_off_us, unused);
    advance_hyst(gps_flag, gps_tmr, use_gps, it.dt_us,
                 lim.gps_switch_us, lim.gps_switch_us, fell);
    r.fail_p     = fell;
    r.hold_mm    = sonar_hold;
    r.gps_usable = use_gps;
    r.sonar_ok   = sonar_flag;
    r.flow_ok    = flow_flag;
    r.gps_ok     = gps_flag;
  endtask

  task automatic send_tick(input in_item_t it);
    int gap;
    health_res_t r;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, it.gps_hacc_cm, it.gps_fix, it.flow_quality, it.sonar_mm, it.dt_us};
    in_tuser  <= it.sonar_valid;
    do @(posedge clk); while (!in_tready);
    predict_health(it, r);
    health_q.push_back(r);
  endtask

  task automatic settle();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (health_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (health_q.size() != 0) begin
      flag_error($sformatf("%0d result beats never arrived", health_q.size()));
      health_q.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs();
    for (int i = 0; i < N_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= cfg_idx_t'(i);
      cfg_wdata <= cfg_raw[i];
      @(posedge clk);
      case (cfg_idx_t'(i))
        REG_FLOW_ON:       lim.flow_on_us        = cfg_raw[i];
        REG_FLOW_OFF:      lim.flow_off_us       = cfg_raw[i];
        REG_SONAR_ON:      lim.sonar_on_us       = cfg_raw[i];
        REG_SONAR_OFF:     lim.sonar_off_us      = cfg_raw[i];
        REG_GPS_SWITCH:    lim.gps_switch_us     = cfg_raw[i];
        REG_FLOW_QUAL_MIN: lim.flow_quality_min  = cfg_raw[i][QUAL_W-1:0];
        REG_HACC_ENTER:    lim.gps_hacc_enter_cm = cfg_raw[i][HACC_W-1:0];
        REG_HACC_STAY:     lim.gps_hacc_stay_cm  = cfg_raw[i][HACC_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic reconfigure(input logic [CFG_DAT_W-1:0] fon, foff, son, soff, gsw,
                             qmin, henter, hstay);
    settle();
    cfg_raw[REG_FLOW_ON]       = fon;
    cfg_raw[REG_FLOW_OFF]      = foff;
    cfg_raw[REG_SONAR_ON]      = son;
    cfg_raw[REG_SONAR_OFF]     = soff;
    cfg_raw[REG_GPS_SWITCH]    = gsw;
    cfg_raw[REG_FLOW_QUAL_MIN] = qmin;
    cfg_raw[REG_HACC_ENTER]    = henter;
    cfg_raw[REG_HACC_STAY]     = hstay;
    program_regs();
  endtask

  function automatic in_item_t tick(input logic [DT_W-1:0] dt, input logic valid,
                                    input logic [RANGE_W-1:0] mm,
                                    input logic [QUAL_W-1:0] fq,
                                    input logic [FIX_W-1:0] fix,
                                    input logic [HACC_W-1:0] hacc);
    in_item_t it;
    it.dt_us        = dt;
    it.sonar_valid  = valid;
    it.sonar_mm     = mm;
    it.flow_quality = fq;
    it.gps_fix      = fix;
    it.gps_hacc_cm  = hacc;
    return it;
  endfunction

  function automatic logic [LIM_W-1:0] rand_window();
    return LIM_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 16000000) :
                                                $urandom_range(0, 250000));
  endfunction

  // persistent good/bad conditions so the hysteresis timers run out
  function automatic in_item_t gen_tick();
    in_item_t it;
    int hmax;
    if ($urandom_range(0, 9) == 0) gps_good = ~gps_good;
    if ($urandom_range(0, 9) == 0) flow_good = ~flow_good;
    if ($urandom_range(0, 9) == 0) sonar_good = ~sonar_good;
    if ($urandom_range(0, 6) == 0) begin
      it = tick(DT_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                RANGE_W'($urandom_range(0, 65535)), QUAL_W'($urandom_range(0, 255)),
                FIX_W'($urandom_range(0, 7)), HACC_W'($urandom_range(0, 65535)));
      return it;
    end
    case ($urandom_range(0, 9))
      0:       it.dt_us = '0;
      1:       it.dt_us = '1;
      default: it.dt_us = DT_W'($urandom_range(0, 65535) >> $urandom_range(0, 5));
    endcase
    it.sonar_valid = (flow_good || sonar_good) ? 1'b1 : 1'($urandom_range(0, 1));
    if (sonar_good) begin
      it.sonar_mm = RANGE_W'($urandom_range(1, int'(SONAR_LIMIT_MM) - 1));
    end else if ($urandom_range(0, 1) == 0) begin
      it.sonar_mm = '0;
    end else begin
      it.sonar_mm = RANGE_W'($urandom_range(int'(SONAR_LIMIT_MM), 65535));
    end
    if (flow_good) begin
      it.flow_quality = (lim.flow_quality_min == '1) ? '1 :
                        QUAL_W'($urandom_range(int'(lim.flow_quality_min) + 1, 255));
    end else begin
      it.flow_quality = QUAL_W'($urandom_range(0, int'(lim.flow_quality_min)));
    end
    if (gps_good) begin
      if ($urandom_range(0, 2) != 0) begin
        it.gps_fix     = GPS_FIX_3D;
        it.gps_hacc_cm = (lim.gps_hacc_enter_cm == '0) ? '0 :
                         HACC_W'($urandom_range(0, int'(lim.gps_hacc_enter_cm) - 1));
      end else begin
        it.gps_fix     = FIX_W'($urandom_range(0, 7));
        it.gps_hacc_cm = (lim.gps_hacc_stay_cm == '0) ? '0 :
                         HACC_W'($urandom_range(0, int'(lim.gps_hacc_stay_cm) - 1));
      end
    end else begin
      hmax = (lim.gps_hacc_enter_cm > lim.gps_hacc_stay_cm) ?
             int'(lim.gps_hacc_enter_cm) : int'(lim.gps_hacc_stay_cm);
      it.gps_fix     = FIX_W'($urandom_range(0, 7));
      it.gps_hacc_cm = HACC_W'($urandom_range(hmax, 65535));
    end
    return it;
  endfunction

  task automatic test_reset_defaults();
    send_tick(tick(16'hFFFF, 1'b1, 16'd4499, 8'd172, GPS_FIX_3D, 16'd349));
    send_tick(tick(16'hFFFF, 1'b1, 16'd4500, 8'd171, GPS_FIX_3D, 16'd350));
    send_tick(tick(16'd0, 1'b0, 16'd1, 8'd255, 3'd7, 16'd0));
  endtask

  task automatic test_directed_edges();
    reconfigure(24'd100, 24'd100, 24'd100, 24'd100, 24'd100, 24'd0, 24'd1000, 24'd2000);
    // zero elapsed time keeps the open pulse coming
    send_tick(tick(16'd0, 1'b0, 16'd0, 8'd0, GPS_FIX_3D, 16'd0));
    send_tick(tick(16'd0, 1'b0, 16'd0, 8'd0, GPS_FIX_3D, 16'd0));
    send_tick(tick(16'd101, 1'b0, 16'd0, 8'd0, GPS_FIX_3D, 16'd999));
    send_tick(tick(16'd50, 1'b0, 16'd0, 8'd0, 3'd0, 16'd1999));
    send_tick(tick(16'd60, 1'b0, 16'd0, 8'd0, GPS_FIX_3D, 16'd2000));
    send_tick(tick(16'd41, 1'b0, 16'd0, 8'd0, GPS_FIX_3D, 16'hFFFF));
    // sonar and flow edges
    send_tick(tick(16'd200, 1'b1, 16'd0, 8'd0, 3'd2, 16'd0));
    send_tick(tick(16'd200, 1'b1, 16'd1, 8'd1, 3'd4, 16'd0));
    send_tick(tick(16'd100, 1'b1, 16'd4500, 8'd0, 3'd5, 16'd0));
    send_tick(tick(16'd1, 1'b1, 16'hFFFF, 8'd0, 3'd6, 16'd0));
    send_tick(tick(16'hFFFF, 1'b0, 16'd2000, 8'd255, 3'd1, 16'd0));
    send_tick(tick(16'hFFFF, 1'b1, 16'd4499, 8'd255, GPS_FIX_3D, 16'hFFFF));
    send_tick(tick(16'hFFFF, 1'b1, 16'hFFFF, 8'd255, GPS_FIX_3D, 16'd1000));
  endtask

  task automatic test_wide_writes();
    // upper bits of narrow registers are dropped
    reconfigure(24'd150, 24'd150, 24'd150, 24'd150, 24'd150,
                24'hA5A5C8, 24'h7F0190, 24'hFF0320);
    send_tick(tick(16'd100, 1'b1, 16'd3000, 8'd201, GPS_FIX_3D, 16'd399));
    send_tick(tick(16'd100, 1'b1, 16'd3000, 8'd200, GPS_FIX_3D, 16'd400));
    send_tick(tick(16'd0, 1'b0, 16'd3000, 8'd201, GPS_FIX_3D, 16'd799));
  endtask

  task automatic test_random_sweep();
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: reconfigure('0, '0, '0, '0, '0, '0, '0, '0);
        1: reconfigure(24'd16000000, 24'd16000000, 24'd16000000, 24'd16000000,
                       24'd16000000, 24'd255, 24'd65535, 24'd65535);
        2: reconfigure(RST_FLOW_ON, RST_FLOW_OFF, RST_SONAR_ON, RST_SONAR_OFF,
                       RST_GPS_SWITCH, CFG_DAT_W'(RST_QUAL_MIN),
                       CFG_DAT_W'(RST_HACC_ENTER), CFG_DAT_W'(RST_HACC_STAY));
        default: reconfigure(rand_window(), rand_window(), rand_window(), rand_window(),
                             rand_window(), CFG_DAT_W'($urandom_range(0, 255)),
                             CFG_DAT_W'($urandom_range(0, 2000)),
                             CFG_DAT_W'($urandom_range(0, 4000)));
      endcase
      for (int n = 0; n < 70; n++) begin
        if (n % 20 == 0) begin
          tx_idle = 1'($urandom_range(0, 1));
          rx_idle = 1'($urandom_range(0, 1));
        end
        send_tick(gen_tick());
      end
    end
  endtask

  task automatic test_output_stall();
    reconfigure(rand_window(), rand_window(), rand_window(), rand_window(), rand_window(),
                CFG_DAT_W'($urandom_range(0, 255)), CFG_DAT_W'($urandom_range(0, 2000)),
                CFG_DAT_W'($urandom_range(0, 4000)));
    tx_idle = 1'b0;
    rx_hold_req = 120;
    for (int n = 0; n < 40; n++) begin
      send_tick(gen_tick());
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // result side
  initial begin : rx_side
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_req) @(posedge clk);
        rx_hold_req = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 7) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_r = out_tdata[21:0];
      if (health_q.size() == 0) begin
        flag_error($sformatf("unexpected result beat %h", got_r));
      end else begin
        exp_r = health_q.pop_front();
        if (got_r.gps_ok !== exp_r.gps_ok || got_r.flow_ok !== exp_r.flow_ok ||
            got_r.sonar_ok !== exp_r.sonar_ok || got_r.gps_usable !== exp_r.gps_usable ||
            got_r.hold_mm !== exp_r.hold_mm || got_r.open_p !== exp_r.open_p ||
            got_r.fail_p !== exp_r.fail_p) begin
          flag_error($sformatf({"mismatch gps/flow/sonar/usable/hold/open/fail ",
                                "exp %b %b %b %b %0d %b %b got %b %b %b %b %0d %b %b"},
                               exp_r.gps_ok, exp_r.flow_ok, exp_r.sonar_ok,
                               exp_r.gps_usable, exp_r.hold_mm, exp_r.open_p,
                               exp_r.fail_p, got_r.gps_ok, got_r.flow_ok,
                               got_r.sonar_ok, got_r.gps_usable, got_r.hold_mm,
                               got_r.open_p, got_r.fail_p));
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("[nav_sensor_health_qualifier_unit] ERROR");
    $finish;
  end

  initial begin
    lim.flow_on_us        = RST_FLOW_ON;
    lim.flow_off_us       = RST_FLOW_OFF;
    lim.sonar_on_us       = RST_SONAR_ON;
    lim.sonar_off_us      = RST_SONAR_OFF;
    lim.gps_switch_us     = RST_GPS_SWITCH;
    lim.flow_quality_min  = RST_QUAL_MIN;
    lim.gps_hacc_enter_cm = RST_HACC_ENTER;
    lim.gps_hacc_stay_cm  = RST_HACC_STAY;
    {gps_flag, flow_flag, sonar_flag} = '0;
    {gps_tmr, flow_tmr, sonar_tmr} = '0;
    sonar_hold = '0;
    {gps_good, flow_good, sonar_good} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_edges();
    test_wide_writes();
    test_random_sweep();
    test_output_stall();
    settle();
    if (n_err == 0) begin
      $display("[nav_sensor_health_qualifier_unit] OK");
    end else begin
      $display("[nav_sensor_health_qualifier_unit] ERROR");
    end
    $finish;
  end

endmodule

[nav_sensor_health_qualifier_unit.f]
rtl/nshq_pkg.sv
rtl/nshq_cfg_regs.sv
rtl/nshq_hyst.sv
rtl/nav_sensor_health_qualifier_unit.sv
verif/tb_top.sv
